/* design/pqi_pkg.sv */
// shared constants and codes for the piecewise quadratic interpolator
package pqi_pkg;

   // field widths fixed by the item format
   localparam int MANT_BITS       = 23;
   localparam int ROW_BITS        = 7;
   localparam int SEG_SEL_BITS    = 3;
   localparam int ROW_COUNT_BITS  = 8;
   localparam int VALUE_BITS      = 45;
   localparam int RSP_DATA_BITS   = 48;
   localparam int RSP_PAD_BITS    = RSP_DATA_BITS - VALUE_BITS;

   // fixed-point alignment of the polynomial terms
   localparam int SQ_SHIFT        = 19;
   localparam int C0_SHIFT        = 14;
   localparam int SQ_BITS         = 2 * MANT_BITS - SQ_SHIFT;

   // parameter defaults
   localparam int SEG_DEPTH_DEF   = 128;
   localparam int CONST_WIDTH_DEF = 27;
   localparam int SLOPE_WIDTH_DEF = 20;
   localparam int CURVE_WIDTH_DEF = 14;

   // configuration port
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;
   localparam logic [SEG_SEL_BITS-1:0]   SEG_BITS_RESET  = 3'd7;
   localparam logic [ROW_COUNT_BITS-1:0] ROW_COUNT_RESET = 8'd128;

   typedef enum logic {
      REG_SEGMENT_BITS = 1'b0,
      REG_ROW_COUNT    = 1'b1
   } reg_index_type;

   typedef enum logic {
      CMD_INTERP = 1'b0,
      CMD_WRITE  = 1'b1
   } cmd_type;

endpackage

/* design/piecewise_quadratic_interpolator.sv */
// piecewise quadratic interpolator: segment store, four-stage datapath, csr port
//
// Each input word is either a row write (tuser = 1) that loads the constant,
// slope and curve coefficients of one segment, or an interpolate request
// (tuser = 0) whose 23-bit mantissa is split into a segment index (top
// segment_bits bits) and a tail; the result is c0*2^14 + c1*tail +
// 2*c2*((tail*tail) >> 19) as a 45-bit two's complement value. Every input
// word produces exactly one result word, in order; writes answer status 0 and
// value 0, and a segment at or above row_count (or beyond the store) answers
// status 1 and value 0. The block takes one word per clock cycle while the
// result channel does not stall, set by the single-port segment store, which
// does one read or one write per cycle; a result passes through the store
// read, square and slope product, curve product and base sum, and the final
// sum into the output register. Stages advance on their own, so bubbles close
// up while the output waits. A write is visible to an interpolate taken in the
// very next cycle. Rows are undefined after reset until written; there is no
// clearing pass. segment_bits and row_count should only be changed while the
// datapath is empty.
module piecewise_quadratic_interpolator #(
   parameter int SEG_DEPTH   = pqi_pkg::SEG_DEPTH_DEF,
   parameter int CONST_WIDTH = pqi_pkg::CONST_WIDTH_DEF,
   parameter int SLOPE_WIDTH = pqi_pkg::SLOPE_WIDTH_DEF,
   parameter int CURVE_WIDTH = pqi_pkg::CURVE_WIDTH_DEF,
   localparam int ReqDataBits = ((pqi_pkg::MANT_BITS + pqi_pkg::ROW_BITS + CONST_WIDTH
                                  + SLOPE_WIDTH + CURVE_WIDTH + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // mantissa, row_index, const_word, slope_word, curve_word, zero pad
   input  logic [ReqDataBits-1:0]                req_tdata,
   // cmd
   input  logic                                  req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // value, zero pad
   output logic [pqi_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // status
   output logic                                  rsp_tuser,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pqi_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [pqi_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [pqi_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   import pqi_pkg::*;

   localparam int AddrBits  = $clog2(SEG_DEPTH);
   localparam int RowWidth  = CONST_WIDTH + SLOPE_WIDTH + CURVE_WIDTH;
   localparam int RowLsb    = MANT_BITS;
   localparam int ConstLsb  = RowLsb + ROW_BITS;
   localparam int SlopeLsb  = ConstLsb + CONST_WIDTH;
   localparam int CurveLsb  = SlopeLsb + SLOPE_WIDTH;
   localparam int P1Bits    = SLOPE_WIDTH + MANT_BITS + 1;
   localparam int P2Bits    = CURVE_WIDTH + SQ_BITS + 1;

   // ---------------------------------------------------------------- csr
   logic [SEG_SEL_BITS-1:0]   seg_bits_ff;
   logic [ROW_COUNT_BITS-1:0] row_count_ff;
   logic                      csr_write;
   reg_index_type             csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // word index, low byte-address bits ignored
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_bits_ff  <= SEG_BITS_RESET;
         row_count_ff <= ROW_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SEGMENT_BITS: seg_bits_ff  <= csr_pwdata[SEG_SEL_BITS-1:0];
            REG_ROW_COUNT:    row_count_ff <= csr_pwdata[ROW_COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SEGMENT_BITS: csr_prdata = CSR_DATA_BITS'(seg_bits_ff);
         REG_ROW_COUNT:    csr_prdata = CSR_DATA_BITS'(row_count_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- stage handshakes
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic adv_out, adv_s3, adv_s2, adv_s1;

   // each stage moves when its successor is empty or moving
   assign adv_out    = !rsp_valid_ff || rsp_tready;
   assign adv_s3     = !s3_valid_ff || adv_out;
   assign adv_s2     = !s2_valid_ff || adv_s3;
   assign adv_s1     = !s1_valid_ff || adv_s2;
   assign req_tready = adv_s1;

   logic req_accept;
   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------- request decode
   cmd_type                 req_cmd;
   logic [MANT_BITS-1:0]    req_mant;
   logic [ROW_BITS-1:0]     req_row;
   logic [4:0]              tail_len;
   logic [MANT_BITS-1:0]    seg_shifted;
   logic [ROW_BITS-1:0]     req_seg;
   logic [MANT_BITS-1:0]    tail_mask;
   logic                    seg_oor;
   logic                    row_in_store;

   assign req_cmd   = cmd_type'(req_tuser);
   assign req_mant  = req_tdata[MANT_BITS-1:0];
   assign req_row   = req_tdata[RowLsb +: ROW_BITS];

   always_comb begin
      tail_len    = 5'(MANT_BITS) - {2'b00, seg_bits_ff};
      seg_shifted = req_mant >> tail_len;
      req_seg     = seg_shifted[ROW_BITS-1:0];
      tail_mask   = {MANT_BITS{1'b1}} >> seg_bits_ff;
      // beyond the programmed row count or beyond the physical store
      seg_oor     = ({1'b0, req_seg} >= row_count_ff)
                 || (32'(req_seg) >= 32'(SEG_DEPTH));
      row_in_store = 32'(req_row) < 32'(SEG_DEPTH);
   end

   // ---------------------------------------------------------------- segment store
   // one port: a write and a read never share a cycle since one word enters per cycle,
   // and a read in the cycle after a write already sees the new row
   logic [RowWidth-1:0] seg_mem [SEG_DEPTH];
   logic [RowWidth-1:0] rd_row_ff;
   logic                mem_we, mem_re;
   logic [AddrBits-1:0] wr_addr, rd_addr;
   logic [RowWidth-1:0] wr_row;

   assign mem_we  = req_accept && (req_cmd == CMD_WRITE) && row_in_store;
   assign mem_re  = req_accept && (req_cmd == CMD_INTERP) && !seg_oor;
   assign wr_addr = AddrBits'(req_row);
   assign rd_addr = AddrBits'(req_seg);
   assign wr_row  = {req_tdata[CurveLsb +: CURVE_WIDTH],
                     req_tdata[SlopeLsb +: SLOPE_WIDTH],
                     req_tdata[ConstLsb +: CONST_WIDTH]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seg_mem[wr_addr] <= wr_row;
      end
      if (mem_re) begin
         rd_row_ff <= seg_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------- stage 1: row read
   logic                 s1_zero_ff, s1_zero_in;
   logic                 s1_status_ff, s1_status_in;
   logic [MANT_BITS-1:0] s1_tail_ff, s1_tail_in;

   always_comb begin
      s1_status_in = (req_cmd == CMD_INTERP) && seg_oor;
      s1_zero_in   = (req_cmd == CMD_WRITE) || seg_oor;
      s1_tail_in   = req_mant & tail_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv_s1) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_accept) begin
         s1_zero_ff   <= s1_zero_in;
         s1_status_ff <= s1_status_in;
         s1_tail_ff   <= s1_tail_in;
      end
   end

   // ---------------------------------------------------------------- stage 2: decode, square, slope
   logic [CONST_WIDTH-2:0]         c0_mag;
   logic [SLOPE_WIDTH-2:0]         c1_mag;
   logic [CURVE_WIDTH-2:0]         c2_mag;
   logic signed [SLOPE_WIDTH-1:0]  c1_dec;
   logic signed [P1Bits-1:0]       p1_full;
   logic [2*MANT_BITS-1:0]         sq_full;

   logic signed [CONST_WIDTH-1:0]  s2_c0_ff, s2_c0_in;
   logic signed [CURVE_WIDTH-1:0]  s2_c2_ff, s2_c2_in;
   logic [SQ_BITS-1:0]             s2_sq_ff, s2_sq_in;
   logic signed [VALUE_BITS-1:0]   s2_p1_ff, s2_p1_in;
   logic                           s2_zero_ff, s2_status_ff;

   always_comb begin
      // sign-magnitude to two's complement; negative zero comes out as zero
      c0_mag   = rd_row_ff[CONST_WIDTH-2:0];
      c1_mag   = rd_row_ff[CONST_WIDTH +: SLOPE_WIDTH-1];
      c2_mag   = rd_row_ff[CONST_WIDTH+SLOPE_WIDTH +: CURVE_WIDTH-1];
      s2_c0_in = rd_row_ff[CONST_WIDTH-1] ? -$signed({1'b0, c0_mag})
                                         :  $signed({1'b0, c0_mag});
      c1_dec   = rd_row_ff[CONST_WIDTH+SLOPE_WIDTH-1] ? -$signed({1'b0, c1_mag})
                                                     :  $signed({1'b0, c1_mag});
      s2_c2_in = rd_row_ff[RowWidth-1] ? -$signed({1'b0, c2_mag})
                                      :  $signed({1'b0, c2_mag});
      sq_full  = s1_tail_ff * s1_tail_ff;
      s2_sq_in = sq_full[2*MANT_BITS-1:SQ_SHIFT];
      p1_full  = c1_dec * $signed({1'b0, s1_tail_ff});
      s2_p1_in = VALUE_BITS'(p1_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv_s2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv_s2 && s1_valid_ff) begin
         s2_c0_ff     <= s2_c0_in;
         s2_c2_ff     <= s2_c2_in;
         s2_sq_ff     <= s2_sq_in;
         s2_p1_ff     <= s2_p1_in;
         s2_zero_ff   <= s1_zero_ff;
         s2_status_ff <= s1_status_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3: curve product, base sum
   logic signed [P2Bits-1:0]      p2_full;
   logic signed [VALUE_BITS-1:0]  c0_ext;
   logic signed [VALUE_BITS-1:0]  s3_base_ff, s3_base_in;
   logic signed [VALUE_BITS-1:0]  s3_p2_ff, s3_p2_in;
   logic                          s3_zero_ff, s3_status_ff;

   always_comb begin
      p2_full    = s2_c2_ff * $signed({1'b0, s2_sq_ff});
      s3_p2_in   = VALUE_BITS'(p2_full);
      c0_ext     = VALUE_BITS'(s2_c0_ff);
      s3_base_in = (c0_ext <<< C0_SHIFT) + s2_p1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv_s3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv_s3 && s2_valid_ff) begin
         s3_base_ff   <= s3_base_in;
         s3_p2_ff     <= s3_p2_in;
         s3_zero_ff   <= s2_zero_ff;
         s3_status_ff <= s2_status_ff;
      end
   end

   // ---------------------------------------------------------------- output register
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_status_ff;

   // sum wraps modulo 2^45; writes and out-of-range segments give zero
   assign rsp_value_in = s3_zero_ff ? '0 : VALUE_BITS'(s3_base_ff + (s3_p2_ff <<< 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_valid_ff <= s3_valid_ff;
      end
      if (adv_out && s3_valid_ff) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= s3_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   // ---------------------------------------------------------------- assertions
   // store port is never asked for a read and a write together
   assert property (@(posedge clock) disable iff (reset) !(mem_we && mem_re))
      else $error("segment store read and write in one cycle");

   // an empty output register always lets a request in
   assert property (@(posedge clock) disable iff (reset) !rsp_valid_ff |-> req_tready)
      else $error("request blocked while output register empty");

   // out-of-range result carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_value_ff == '0))
      else $error("out-of-range word with nonzero value");

   // a stalled last stage keeps its word
   assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !adv_out) |=> (s3_valid_ff && $stable(s3_base_ff)
                                    && $stable(s3_p2_ff)))
      else $error("stage 3 word lost under stall");

endmodule
